[rtl/core/pss_pkg.sv]
// shared types, constants and lookup tables of the pll setting search unit
package pss_pkg;

    // widths of the frequency registers and of the candidate products
    localparam int REG_W    = 25;
    localparam int TARGET_W = 32;
    localparam int PROD_W   = 29;

    // candidate grid: multipliers 16 down to 2, nine ahb divisors
    localparam int NUM_MUL = 15;
    localparam int MUL_MAX = 16;
    localparam int NUM_AHB = 9;
    localparam int NUM_APB = 4;

    // reset value of both frequency registers
    localparam logic [REG_W-1:0] FREQ_RESET = 25'd8000000;

    // lowest accepted target
    localparam logic [TARGET_W-1:0] MIN_TARGET_HZ = 32'd1000000;

    // configuration register indexes
    localparam logic CFG_HSE = 1'b0;
    localparam logic CFG_HSI = 1'b1;

    // pll input source codes
    localparam logic [1:0] SRC_HSI = 2'd0;
    localparam logic [1:0] SRC_HSE = 2'd1;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_PLL    = 3'd1,
        ST_BAD_SOURCE = 3'd2,
        ST_LOW_TARGET = 3'd3,
        ST_NO_MATCH   = 3'd4
    } t_status;

    // ahb divisors 1,2,4,8,16,64,128,256,512 as right shifts
    localparam logic [3:0] AHB_SHIFT [0:NUM_AHB-1] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd9
    };

    // ahb prescaler code per divisor index
    localparam logic [3:0] AHB_CODE [0:NUM_AHB-1] = '{
        4'd0, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
    };

    // apb1 prescaler codes for divide by 2, 4, 8, 16
    localparam logic [2:0] APB_DIV1 = 3'd0;
    localparam logic [2:0] APB_CODE [0:NUM_APB-1] = '{3'd4, 3'd5, 3'd6, 3'd7};

endpackage

[rtl/core/pss_req_if.sv]
// request channel: pll enable flag, input source and target frequency
interface pss_req_if;
    logic        valid;
    logic        ready;
    logic        output_is_pll;
    logic [1:0]  input_source;
    logic [31:0] target_freq;

    modport source (output valid, output output_is_pll, output input_source,
                    output target_freq, input ready);
    modport sink   (input valid, input output_is_pll, input input_source,
                    input target_freq, output ready);
endinterface

[rtl/core/pss_res_if.sv]
// result channel: status and the chosen pll and bus prescaler codes
interface pss_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic       source_select_written;
    logic       pll_source_bit;
    logic [3:0] pll_mul_code;
    logic [3:0] ahb_prescaler_code;
    logic [2:0] apb1_prescaler_code;

    modport source (output valid, output status, output source_select_written,
                    output pll_source_bit, output pll_mul_code,
                    output ahb_prescaler_code, output apb1_prescaler_code,
                    input ready);
    modport sink   (input valid, input status, input source_select_written,
                    input pll_source_bit, input pll_mul_code,
                    input ahb_prescaler_code, input apb1_prescaler_code,
                    output ready);
endinterface

[rtl/core/pll_setting_search_unit.sv]
// pll setting search unit: four stage pipeline picking pll and bus prescaler codes
//
// Requests arrive on i_req (valid/ready) and carry the pll flag, the pll input
// source and the target frequency. Each request gives exactly one result on
// o_res: a status plus the pll multiplier, ahb and apb1 prescaler codes.
// The crystal and internal oscillator frequencies are set through the plain
// write port (i_cfg_wr_en, i_cfg_index, i_cfg_wdata); the user must write it only
// while no request is in flight, and the block itself does not enforce this.
// A request passes the stage 1, 2 and 3 registers into the stage 4 register that
// drives o_res.valid. The four stages are input checks and source select, the
// 15 multiplier products, the 135 quotient compares, then the priority pick into
// the output register. One request is taken every cycle while the result side
// does not stall; the grid compares are fully laid out across the stages.
// Reset clears all stage valid bits and loads both frequency registers with
// 8 MHz. When the receiver stalls, each stage holds its item until the stage
// after it frees up, so a full pipeline keeps four results and then drops
// i_req.ready; nothing is lost or repeated.
module pll_setting_search_unit #(
    parameter int APB1_LIMIT_HZ = 36000000
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic                     i_cfg_index,
    input  logic [pss_pkg::REG_W-1:0] i_cfg_wdata,
    pss_req_if.sink                  i_req,
    pss_res_if.source                o_res
);

    localparam logic [pss_pkg::TARGET_W-1:0] APB1_LIMIT = 32'(APB1_LIMIT_HZ);

    // configuration registers
    logic [pss_pkg::REG_W-1:0] r_hse_hz;
    logic [pss_pkg::REG_W-1:0] r_hsi_hz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hse_hz <= pss_pkg::FREQ_RESET;
            r_hsi_hz <= pss_pkg::FREQ_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                pss_pkg::CFG_HSE: r_hse_hz <= i_cfg_wdata;
                pss_pkg::CFG_HSI: r_hsi_hz <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline registers
    logic                              r1_valid, r2_valid, r3_valid, r4_valid;
    pss_pkg::t_status                  r1_status, r2_status, r3_status, r4_status;
    logic                              r1_src, r2_src, r3_src, r4_src;
    logic [2:0]                        r1_apb, r2_apb, r3_apb, r4_apb;
    logic [pss_pkg::REG_W-1:0]         r1_base;
    logic [pss_pkg::TARGET_W-1:0]      r1_target, r2_target;
    logic [pss_pkg::PROD_W-1:0]        r2_prod [0:pss_pkg::NUM_MUL-1];
    logic [pss_pkg::NUM_MUL-1:0]       r3_hit;
    logic [3:0]                        r3_ahb [0:pss_pkg::NUM_MUL-1];
    logic [3:0]                        r4_mul, r4_ahb;

    // stage load enables: a stage loads when empty or when its item moves on
    logic en1, en2, en3, en4;
    assign en4 = !r4_valid || o_res.ready;
    assign en3 = !r3_valid || en4;
    assign en2 = !r2_valid || en3;
    assign en1 = !r1_valid || en2;
    assign i_req.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (en1) r1_valid <= i_req.valid;
            if (en2) r2_valid <= r1_valid;
            if (en3) r3_valid <= r2_valid;
            if (en4) r4_valid <= r3_valid;
        end
    end

    // stage 1: request checks, pll input select, apb1 code
    pss_pkg::t_status            n1_status;
    logic                        n1_src;
    logic [2:0]                  n1_apb;
    logic [pss_pkg::REG_W-1:0]   n1_base;

    always_comb begin
        n1_src = 1'b0;
        if (!i_req.output_is_pll) begin
            n1_status = pss_pkg::ST_NOT_PLL;
        end else if (!(i_req.input_source inside {pss_pkg::SRC_HSI, pss_pkg::SRC_HSE})) begin
            n1_status = pss_pkg::ST_BAD_SOURCE;
        end else if (i_req.target_freq < pss_pkg::MIN_TARGET_HZ) begin
            n1_status = pss_pkg::ST_LOW_TARGET;
        end else begin
            n1_status = pss_pkg::ST_NO_MATCH;
            n1_src    = (i_req.input_source == pss_pkg::SRC_HSE);
        end
        n1_base = (i_req.input_source == pss_pkg::SRC_HSE) ? r_hse_hz
                                                            : (r_hsi_hz >> 1);
        // smallest divide that brings the target under the limit, saturating
        n1_apb = pss_pkg::APB_CODE[pss_pkg::NUM_APB-1];
        for (int k = pss_pkg::NUM_APB - 1; k >= 0; k--) begin
            if ((i_req.target_freq >> (k + 1)) <= APB1_LIMIT) begin
                n1_apb = pss_pkg::APB_CODE[k];
            end
        end
        if (i_req.target_freq <= APB1_LIMIT) begin
            n1_apb = pss_pkg::APB_DIV1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_status <= n1_status;
            r1_src    <= n1_src;
            r1_apb    <= n1_apb;
            r1_base   <= n1_base;
            r1_target <= i_req.target_freq;
        end
    end

    // stage 2: one product per multiplier, lane j holds multiplier 16 - j
    for (genvar j = 0; j < pss_pkg::NUM_MUL; j++) begin : g_prod
        localparam logic [4:0] MUL = 5'(pss_pkg::MUL_MAX - j);
        always_ff @(posedge i_clk) begin
            if (en2) begin
                r2_prod[j] <= pss_pkg::PROD_W'(r1_base) * pss_pkg::PROD_W'(MUL);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_status <= r1_status;
            r2_src    <= r1_src;
            r2_apb    <= r1_apb;
            r2_target <= r1_target;
        end
    end

    // stage 3: compare each quotient with the target, first divisor per lane
    logic                        n3_hit  [0:pss_pkg::NUM_MUL-1];
    logic [3:0]                  n3_ahb  [0:pss_pkg::NUM_MUL-1];

    for (genvar j = 0; j < pss_pkg::NUM_MUL; j++) begin : g_cmp
        always_comb begin
            n3_hit[j] = 1'b0;
            n3_ahb[j] = pss_pkg::AHB_CODE[0];
            for (int i = pss_pkg::NUM_AHB - 1; i >= 0; i--) begin
                if (pss_pkg::TARGET_W'(r2_prod[j] >> pss_pkg::AHB_SHIFT[i]) == r2_target)
                begin
                    n3_hit[j] = 1'b1;
                    n3_ahb[j] = pss_pkg::AHB_CODE[i];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en3) begin
                r3_hit[j] <= n3_hit[j];
                r3_ahb[j] <= n3_ahb[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_status <= r2_status;
            r3_src    <= r2_src;
            r3_apb    <= r2_apb;
        end
    end

    // stage 4: highest multiplier with a match wins
    pss_pkg::t_status n4_status;
    logic [3:0]       n4_mul, n4_ahb;
    logic [2:0]       n4_apb;

    always_comb begin
        n4_status = r3_status;
        n4_mul    = '0;
        n4_ahb    = '0;
        n4_apb    = pss_pkg::APB_DIV1;
        if (r3_status == pss_pkg::ST_NO_MATCH && |r3_hit) begin
            n4_status = pss_pkg::ST_OK;
            n4_apb    = r3_apb;
            for (int j = pss_pkg::NUM_MUL - 1; j >= 0; j--) begin
                if (r3_hit[j]) begin
                    n4_mul = 4'(pss_pkg::MUL_MAX - 2 - j);
                    n4_ahb = r3_ahb[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_status <= n4_status;
            r4_src    <= r3_src;
            r4_mul    <= n4_mul;
            r4_ahb    <= n4_ahb;
            r4_apb    <= n4_apb;
        end
    end

    // result channel
    assign o_res.valid                 = r4_valid;
    assign o_res.status                = r4_status;
    assign o_res.source_select_written = (r4_status == pss_pkg::ST_OK) ||
                                         (r4_status == pss_pkg::ST_NO_MATCH);
    assign o_res.pll_source_bit        = r4_src;
    assign o_res.pll_mul_code          = r4_mul;
    assign o_res.ahb_prescaler_code    = r4_ahb;
    assign o_res.apb1_prescaler_code   = r4_apb;

    // a held stage keeps its item until the next stage takes it
    a_stage1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_valid && !en2) |=> r1_valid)
        else $error("stage 1 item dropped while stalled");

    // a lane match on a searched request turns into an ok result
    a_match_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en4 && r3_valid && (|r3_hit) && r3_status == pss_pkg::ST_NO_MATCH)
        |=> (r4_status == pss_pkg::ST_OK))
        else $error("matching candidate not reported as ok");

    // rejected requests carry no source select and no codes
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_valid && (r4_status == pss_pkg::ST_NOT_PLL ||
                      r4_status == pss_pkg::ST_BAD_SOURCE ||
                      r4_status == pss_pkg::ST_LOW_TARGET))
        |-> (!r4_src && r4_mul == '0 && r4_ahb == '0 && r4_apb == pss_pkg::APB_DIV1))
        else $error("rejected request carries nonzero codes");

endmodule

[tb/sv/tb_pll_setting_search_unit.sv]
// testbench for the pll setting search unit: predicted settings checked per result transfer
module tb_pll_setting_search_unit;

    // block parameter and settings of this bench
    localparam int APB1_LIMIT_HZ   = 36000000;
    localparam int TARGET_FLOOR_HZ = 1000000;
    localparam int MUL_HIGH        = 16;
    localparam int MUL_LOW         = 2;
    localparam int AHB_COUNT       = 9;
    localparam int APB_STEPS       = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam int TIMEOUT_TU      = 4000000;
    localparam int MAX_PRINTS      = 100;

    // own divisor list and prescaler code rules
    localparam int unsigned AHB_DIV [AHB_COUNT] = '{1, 2, 4, 8, 16, 64, 128, 256, 512};
    localparam logic [3:0] AHB_CODE_DIV1 = 4'd0;
    localparam logic [3:0] AHB_CODE_BASE = 4'd8;
    localparam logic [2:0] APB_CODE_DIV1 = 3'd0;
    localparam logic [2:0] APB_CODE_BASE = 3'd4;
    localparam logic [2:0] APB_CODE_MAX  = 3'd7;

    // input source codes that are not a pll input
    localparam logic [1:0] SRC_OTHER    = 2'd2;
    localparam logic [1:0] SRC_RESERVED = 2'd3;

    // idling phases: sender gap and receiver stall in percent
    localparam int PHASES = 4;
    localparam int GAP_PHASE   [PHASES] = '{0, 61, 0, 21};
    localparam int STALL_PHASE [PHASES] = '{0, 0, 61, 21};

    // one expected result
    typedef struct packed {
        pss_pkg::t_status status;
        logic             written;
        logic             src_bit;
        logic [3:0]       mul_code;
        logic [3:0]       ahb_code;
        logic [2:0]       apb_code;
    } t_setting;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_wr_en;
    logic                      i_cfg_index;
    logic [pss_pkg::REG_W-1:0] i_cfg_wdata;

    pss_req_if req_if ();
    pss_res_if res_if ();

    // shadow of the frequency registers
    logic [pss_pkg::REG_W-1:0] hse_hz;
    logic [pss_pkg::REG_W-1:0] hsi_hz;

    t_setting pending_settings [$];
    t_setting expected_head;
    int       mismatch_count;
    int       gap_pct;
    int       stall_pct;

    pll_setting_search_unit #(
        .APB1_LIMIT_HZ(APB1_LIMIT_HZ)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(TIMEOUT_TU);
        $display("FAIL");
        $finish;
    end

    // apb1 code: smallest division bringing the target to the limit or below
    function automatic logic [2:0] apb1_code_for(input logic [31:0] tgt);
        int k;
        if (tgt <= APB1_LIMIT_HZ) return APB_CODE_DIV1;
        for (k = 0; k < APB_STEPS; k++) begin
            if ((tgt >> (k + 1)) <= APB1_LIMIT_HZ) return APB_CODE_BASE | 3'(k);
        end
        return APB_CODE_MAX;
    endfunction

    // expected setting for one request under the current registers
    function automatic t_setting predict_setting(input logic pll, input logic [1:0] src,
                                                 input logic [31:0] tgt);
        t_setting    r;
        logic [63:0] base;
        logic [63:0] prod;
        bit          found;
        int          m;
        int          i;
        r     = '0;
        found = 1'b0;
        if (!pll) begin
            r.status = pss_pkg::ST_NOT_PLL;
        end else if (src != pss_pkg::SRC_HSI && src != pss_pkg::SRC_HSE) begin
            r.status = pss_pkg::ST_BAD_SOURCE;
        end else if (tgt < TARGET_FLOOR_HZ) begin
            r.status = pss_pkg::ST_LOW_TARGET;
        end else begin
            base      = (src == pss_pkg::SRC_HSE) ? 64'(hse_hz) : 64'(hsi_hz >> 1);
            r.written = 1'b1;
            r.src_bit = (src == pss_pkg::SRC_HSE);
            r.status  = pss_pkg::ST_NO_MATCH;
            // first multiplier from the top, first divisor from the bottom
            for (m = MUL_HIGH; m >= MUL_LOW && !found; m--) begin
                prod = base * 64'(m);
                for (i = 0; i < AHB_COUNT && !found; i++) begin
                    if (prod / 64'(AHB_DIV[i]) == 64'(tgt)) begin
                        found      = 1'b1;
                        r.status   = pss_pkg::ST_OK;
                        r.mul_code = 4'(m - MUL_LOW);
                        r.ahb_code = (i == 0) ? AHB_CODE_DIV1 : (AHB_CODE_BASE | 4'(i - 1));
                        r.apb_code = apb1_code_for(tgt);
                    end
                end
            end
        end
        return r;
    endfunction

    // a target that some grid point reaches for this source
    function automatic logic [31:0] matching_target(input logic [1:0] src);
        logic [63:0] base;
        logic [63:0] prod;
        base = (src == pss_pkg::SRC_HSE) ? 64'(hse_hz) : 64'(hsi_hz >> 1);
        prod = base * 64'($urandom_range(MUL_LOW, MUL_HIGH));
        return 32'(prod / 64'(AHB_DIV[$urandom_range(0, AHB_COUNT - 1)]));
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_count < MAX_PRINTS)
            $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // one request transfer, with random idle cycles ahead of it
    task automatic send_request(input logic pll, input logic [1:0] src, input logic [31:0] tgt);
        while ($urandom_range(0, 99) < gap_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.output_is_pll <= pll;
        req_if.input_source  <= src;
        req_if.target_freq   <= tgt;
        pending_settings.push_back(predict_setting(pll, src, tgt));
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
    endtask

    // stop sending and let every pending result come out
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (pending_settings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_freq(input logic idx, input logic [pss_pkg::REG_W-1:0] hz);
        wait_idle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= hz;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == pss_pkg::CFG_HSE) hse_hz = hz;
        else hsi_hz = hz;
    endtask

    task automatic write_both(input logic [pss_pkg::REG_W-1:0] hse,
                              input logic [pss_pkg::REG_W-1:0] hsi);
        write_freq(pss_pkg::CFG_HSE, hse);
        write_freq(pss_pkg::CFG_HSI, hsi);
    endtask

    // mostly reachable targets, then near misses, every reject path and plain random targets
    task automatic send_random_request();
        int          kind;
        logic        pll;
        logic [1:0]  src;
        logic [31:0] tgt;
        kind = $urandom_range(0, 99);
        pll  = 1'b1;
        src  = $urandom_range(0, 1) ? pss_pkg::SRC_HSE : pss_pkg::SRC_HSI;
        tgt  = $urandom;
        if (kind < 65) begin
            tgt = matching_target(src);
        end else if (kind < 75) begin
            tgt = matching_target(src) + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
        end else if (kind < 80) begin
            tgt = $urandom_range(0, TARGET_FLOOR_HZ - 1);
        end else if (kind < 88) begin
            src = $urandom_range(0, 1) ? SRC_OTHER : SRC_RESERVED;
        end else if (kind < 94) begin
            pll = 1'b0;
            src = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 1)) tgt = matching_target(pss_pkg::SRC_HSE);
        end
        send_request(pll, src, tgt);
    endtask

    // result side: random stalls, each transfer checked against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (pending_settings.size() == 0) begin
                report_mismatch("result with nothing pending, status", res_if.status, 0);
            end else begin
                expected_head = pending_settings.pop_front();
                if (res_if.status !== expected_head.status)
                    report_mismatch("status", res_if.status, expected_head.status);
                if (res_if.source_select_written !== expected_head.written)
                    report_mismatch("source_select_written", res_if.source_select_written,
                                    expected_head.written);
                if (res_if.pll_source_bit !== expected_head.src_bit)
                    report_mismatch("pll_source_bit", res_if.pll_source_bit,
                                    expected_head.src_bit);
                if (res_if.pll_mul_code !== expected_head.mul_code)
                    report_mismatch("pll_mul_code", res_if.pll_mul_code, expected_head.mul_code);
                if (res_if.ahb_prescaler_code !== expected_head.ahb_code)
                    report_mismatch("ahb_prescaler_code", res_if.ahb_prescaler_code,
                                    expected_head.ahb_code);
                if (res_if.apb1_prescaler_code !== expected_head.apb_code)
                    report_mismatch("apb1_prescaler_code", res_if.apb1_prescaler_code,
                                    expected_head.apb_code);
            end
        end
        res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // every reject path, checked in priority order, with the reset registers
    task automatic test_rejections();
        send_request(1'b0, SRC_RESERVED, 32'd0);
        send_request(1'b0, pss_pkg::SRC_HSE, 32'd128000000);
        send_request(1'b0, SRC_OTHER, 32'hFFFF_FFFF);
        send_request(1'b1, SRC_OTHER, 32'd128000000);
        send_request(1'b1, SRC_RESERVED, 32'hFFFF_FFFF);
        send_request(1'b1, pss_pkg::SRC_HSE, 32'd0);
        send_request(1'b1, pss_pkg::SRC_HSI, 32'd999999);
    endtask

    // searches against the reset frequencies: floor, apb1 boundaries, no match
    task automatic test_reset_settings();
        send_request(1'b1, pss_pkg::SRC_HSE, 32'd1000000);
        send_request(1'b1, pss_pkg::SRC_HSI, 32'd1000000);
        send_request(1'b1, pss_pkg::SRC_HSE, 32'd128000000);
        send_request(1'b1, pss_pkg::SRC_HSI, 32'd64000000);
        send_request(1'b1, pss_pkg::SRC_HSE, 32'd36000000);
        send_request(1'b1, pss_pkg::SRC_HSE, 32'd36000001);
        send_request(1'b1, pss_pkg::SRC_HSE, 32'd72000000);
        send_request(1'b1, pss_pkg::SRC_HSE, 32'd8000000);
        send_request(1'b1, pss_pkg::SRC_HSI, 32'd16000000);
        send_request(1'b1, pss_pkg::SRC_HSE, 32'hFFFF_FFFF);
        send_request(1'b1, pss_pkg::SRC_HSI, 32'd64000001);
    endtask

    // register extremes, including an internal oscillator that halves to zero
    task automatic test_register_extremes();
        int n;
        gap_pct   = GAP_PHASE[PHASES - 1];
        stall_pct = STALL_PHASE[PHASES - 1];
        write_both(25'd25000000, 25'd1);
        for (n = 0; n < 80; n++) send_random_request();
        write_both(25'd1, 25'd25000000);
        for (n = 0; n < 80; n++) send_random_request();
        write_both(25'd16000000, 25'd2);
        for (n = 0; n < 80; n++) send_random_request();
        write_both(25'd25000000, 25'd3);
        for (n = 0; n < 80; n++) send_random_request();
    endtask

    // random registers and traffic through each idling phase
    task automatic test_random_traffic();
        int p;
        int n;
        for (p = 0; p < PHASES; p++) begin
            write_freq(pss_pkg::CFG_HSE,
                       $urandom_range(0, 1) ? 25'($urandom_range(1, 25) * 1000000)
                                            : 25'($urandom_range(1, 25000000)));
            write_freq(pss_pkg::CFG_HSI,
                       $urandom_range(0, 1) ? 25'($urandom_range(1, 25) * 1000000)
                                            : 25'($urandom_range(1, 25000000)));
            gap_pct   = GAP_PHASE[p];
            stall_pct = STALL_PHASE[p];
            for (n = 0; n < 350; n++) send_random_request();
        end
    endtask

    // reset, then the tests in turn
    initial begin
        i_rst_n              = 1'b0;
        i_cfg_wr_en          = 1'b0;
        i_cfg_index          = pss_pkg::CFG_HSE;
        i_cfg_wdata          = '0;
        req_if.valid         = 1'b0;
        req_if.output_is_pll = 1'b0;
        req_if.input_source  = pss_pkg::SRC_HSI;
        req_if.target_freq   = '0;
        res_if.ready         = 1'b0;
        hse_hz               = pss_pkg::FREQ_RESET;
        hsi_hz               = pss_pkg::FREQ_RESET;
        mismatch_count       = 0;
        gap_pct              = 0;
        stall_pct            = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_rejections();
        test_reset_settings();
        test_register_extremes();
        test_random_traffic();

        wait_idle();
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/pss_pkg.sv
rtl/core/pss_req_if.sv
rtl/core/pss_res_if.sv
rtl/core/pll_setting_search_unit.sv
tb/sv/tb_pll_setting_search_unit.sv
